>>> hdl/assert_macros.svh
// Assertion macros for the RTL of the B-spline weight block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

>>> hdl/cbsw_pkg.sv
// Package with widths, defaults and register indexes of the B-spline weight block.
package cbsw_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int DATA_W        = 32;
	localparam int WEIGHT_W      = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int IN_TDATA_W    = 2 * DATA_W;
	localparam int OUT_TDATA_W   = WEIGHT_W + 2 * DATA_W;

	localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_Y = 2'd1;
endpackage

>>> hdl/cubic_bspline_shape_weight_2d.sv
// An input transaction passes through every stage register in order before its result reaches the master side.
// Throughput: one node offset per cycle; each stage holds on its own, so a stalled
// output stops only the stages behind a full one.
// The deepest path per stage is one multiplier of up to 32 by 32 bits or 33 by 17 bits.
// Reset clears all stage valid bits and sets both inverse cell lengths to 1.0.
`include "assert_macros.svh"

module cubic_bspline_shape_weight_2d #(
	parameter int FRAC_BITS = cbsw_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [cbsw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cbsw_pkg::DATA_W-1:0]        cfg_data,
	// slave side
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [cbsw_pkg::IN_TDATA_W-1:0]    s_tdata,   // offset_x, offset_y
	// master side
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [cbsw_pkg::OUT_TDATA_W-1:0]   m_tdata,   // weight, grad_x, grad_y
	output logic                               m_tuser    // out_of_range
);
	import cbsw_pkg::*;

	localparam int AW     = FRAC_BITS + 1;      // magnitudes up to 1.0
	localparam int GW     = AW + DATA_W - FRAC_BITS;
	localparam int MW     = GW + AW - FRAC_BITS;
	localparam int DIV_K  = AW + 3;
	localparam longint unsigned DIV_M_L = ((64'd1 << DIV_K) + 64'd5) / 64'd6;
	localparam logic [DIV_K-1:0] DIV_M = DIV_M_L[DIV_K-1:0];
	localparam longint unsigned TWO_3_L = ((64'd2 << FRAC_BITS) + 64'd1) / 64'd3;
	localparam logic [AW-1:0] TWO_THIRDS = TWO_3_L[AW-1:0];
	localparam logic [AW:0]   TWO_Q = (AW+1)'(2) << FRAC_BITS;
	localparam logic [DATA_W-1:0] INV_RESET = DATA_W'(1) << FRAC_BITS;
	localparam logic [MW-1:0] POS_MAX = MW'(32'h7FFF_FFFF);
	localparam logic [MW-1:0] NEG_MAX = MW'(32'h8000_0000);

	// configuration registers
	logic [DATA_W-1:0] inv_q [2];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q[0] <= INV_RESET;
			inv_q[1] <= INV_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_INV_CELL_X: inv_q[0] <= cfg_data;
				CFG_INV_CELL_Y: inv_q[1] <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage valid bits and per-stage advance
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic [8:1] en;

	always_comb begin
		en[8] = !v_s8 || m_tready;
		en[7] = !v_s7 || en[8];
		en[6] = !v_s6 || en[7];
		en[5] = !v_s5 || en[6];
		en[4] = !v_s4 || en[5];
		en[3] = !v_s3 || en[4];
		en[2] = !v_s2 || en[3];
		en[1] = !v_s1 || en[2];
	end

	assign s_tready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else begin
			if (en[1]) v_s1 <= s_tvalid;
			if (en[2]) v_s2 <= v_s1;
			if (en[3]) v_s3 <= v_s2;
			if (en[4]) v_s4 <= v_s3;
			if (en[5]) v_s5 <= v_s4;
			if (en[6]) v_s6 <= v_s5;
			if (en[7]) v_s7 <= v_s6;
			if (en[8]) v_s8 <= v_s7;
		end
	end

	// stage 1: sign split and scaling by the inverse cell length
	logic [DATA_W-1:0]   off_c [2];
	logic [DATA_W-1:0]   mag_c [2];
	logic [2*DATA_W-1:0] prod_s1 [2];
	logic [1:0]          neg_s1;

	always_comb begin
		off_c[0] = s_tdata[DATA_W-1:0];
		off_c[1] = s_tdata[2*DATA_W-1:DATA_W];
		for (int i = 0; i < 2; i++) begin
			mag_c[i] = off_c[i][DATA_W-1] ? (~off_c[i] + DATA_W'(1)) : off_c[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < 2; i++) begin
				prod_s1[i] <= mag_c[i] * inv_q[i];
				neg_s1[i]  <= off_c[i][DATA_W-1];
			end
		end
	end

	// stage 2: range check and branch operand (a or 2 - a)
	logic [AW:0]   a_c [2];
	logic [AW:0]   d_c [2];
	logic [1:0]    oor_c;
	logic [AW-1:0] x_s2 [2];
	logic [1:0]    outer_s2, neg_s2;
	logic          oor_s2;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			// scaled magnitude of 2.0 or more sets a product bit at 2F+1 or above
			oor_c[i] = |prod_s1[i][2*DATA_W-1:2*FRAC_BITS+1];
			a_c[i]   = {1'b0, prod_s1[i][2*FRAC_BITS:FRAC_BITS]};
			d_c[i]   = TWO_Q - a_c[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < 2; i++) begin
				outer_s2[i] <= a_c[i][FRAC_BITS];
				x_s2[i]     <= a_c[i][FRAC_BITS] ? d_c[i][AW-1:0] : a_c[i][AW-1:0];
			end
			neg_s2 <= neg_s1;
			oor_s2 <= |oor_c;
		end
	end

	// stage 3: square
	logic [2*AW-1:0] sqf_c [2];
	logic [AW-1:0]   x_s3 [2];
	logic [AW-1:0]   sq_s3 [2];
	logic [1:0]      outer_s3, neg_s3;
	logic            oor_s3;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			sqf_c[i] = x_s2[i] * x_s2[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int i = 0; i < 2; i++) begin
				x_s3[i]  <= x_s2[i];
				sq_s3[i] <= sqf_c[i][AW+FRAC_BITS-1:FRAC_BITS];
			end
			outer_s3 <= outer_s2;
			neg_s3   <= neg_s2;
			oor_s3   <= oor_s2;
		end
	end

	// stage 4: cube and derivative magnitude
	logic [2*AW-1:0] cbf_c [2];
	logic [AW+1:0]   sq3_c [2];
	logic [AW+1:0]   gin_c [2];
	logic [AW-1:0]   sq_s4 [2];
	logic [AW-1:0]   cube_s4 [2];
	logic [AW-1:0]   gm_s4 [2];
	logic [1:0]      outer_s4, neg_s4;
	logic            oor_s4;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			cbf_c[i] = sq_s3[i] * x_s3[i];
			sq3_c[i] = ({2'b00, sq_s3[i]} + {1'b0, sq_s3[i], 1'b0}) >> 1;
			gin_c[i] = {1'b0, x_s3[i], 1'b0} - sq3_c[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int i = 0; i < 2; i++) begin
				sq_s4[i]   <= sq_s3[i];
				cube_s4[i] <= cbf_c[i][AW+FRAC_BITS-1:FRAC_BITS];
				gm_s4[i]   <= outer_s3[i] ? (sq_s3[i] >> 1) : gin_c[i][AW-1:0];
			end
			outer_s4 <= outer_s3;
			neg_s4   <= neg_s3;
			oor_s4   <= oor_s3;
		end
	end

	// stage 5: axis weight; divide by six through the reciprocal
	logic [AW+DIV_K-1:0] d6_c [2];
	logic [AW:0]         win_c [2];
	logic [AW-1:0]       w_s5 [2];
	logic [AW-1:0]       gm_s5 [2];
	logic [1:0]          neg_s5;
	logic                oor_s5;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			d6_c[i]  = cube_s4[i] * DIV_M;
			win_c[i] = ({1'b0, cube_s4[i] >> 1} + {1'b0, TWO_THIRDS}) - {1'b0, sq_s4[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int i = 0; i < 2; i++) begin
				w_s5[i]  <= outer_s4[i] ? d6_c[i][AW+DIV_K-1:DIV_K] : win_c[i][AW-1:0];
				gm_s5[i] <= gm_s4[i];
			end
			neg_s5 <= neg_s4;
			oor_s5 <= oor_s4;
		end
	end

	// stage 6: node weight and derivative scaled by the inverse cell length
	logic [2*AW-1:0]     wp_c;
	logic [AW+DATA_W-1:0] gsf_c [2];
	logic [WEIGHT_W-1:0] weight_s6;
	logic [GW-1:0]       gs_s6 [2];
	logic [AW-1:0]       w_s6 [2];
	logic [1:0]          neg_s6;
	logic                oor_s6;

	always_comb begin
		wp_c = w_s5[0] * w_s5[1];
		for (int i = 0; i < 2; i++) begin
			gsf_c[i] = gm_s5[i] * inv_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			weight_s6 <= wp_c[2*FRAC_BITS-1:2*FRAC_BITS-WEIGHT_W];
			for (int i = 0; i < 2; i++) begin
				gs_s6[i] <= gsf_c[i][AW+DATA_W-1:FRAC_BITS];
				w_s6[i]  <= w_s5[i];
			end
			neg_s6 <= neg_s5;
			oor_s6 <= oor_s5;
		end
	end

	// stage 7: gradient magnitude times the other axis weight
	logic [GW+AW-1:0]    mgf_c [2];
	logic [MW-1:0]       mag_s7 [2];
	logic [WEIGHT_W-1:0] weight_s7;
	logic [1:0]          neg_s7;
	logic                oor_s7;

	always_comb begin
		mgf_c[0] = gs_s6[0] * w_s6[1];
		mgf_c[1] = gs_s6[1] * w_s6[0];
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			for (int i = 0; i < 2; i++) begin
				mag_s7[i] <= mgf_c[i][GW+AW-1:FRAC_BITS];
			end
			weight_s7 <= weight_s6;
			neg_s7    <= neg_s6;
			oor_s7    <= oor_s6;
		end
	end

	// stage 8: sign, saturation and out-of-range zeroing into the output register
	logic [DATA_W-1:0]   grad_c [2];
	logic [DATA_W-1:0]   grad_s8 [2];
	logic [WEIGHT_W-1:0] weight_s8;
	logic                oor_s8;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			if (oor_s7) begin
				grad_c[i] = '0;
			end else if (neg_s7[i]) begin
				grad_c[i] = (mag_s7[i] > POS_MAX) ? POS_MAX[DATA_W-1:0] : mag_s7[i][DATA_W-1:0];
			end else if (mag_s7[i] > NEG_MAX) begin
				grad_c[i] = NEG_MAX[DATA_W-1:0];
			end else begin
				grad_c[i] = ~mag_s7[i][DATA_W-1:0] + DATA_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			grad_s8[0] <= grad_c[0];
			grad_s8[1] <= grad_c[1];
			weight_s8  <= oor_s7 ? '0 : weight_s7;
			oor_s8     <= oor_s7;
		end
	end

	assign m_tvalid = v_s8;
	assign m_tdata  = {grad_s8[1], grad_s8[0], weight_s8};
	assign m_tuser  = oor_s8;

	`ASSERT_CLK(a_oor_zero, clk, arst_n, m_tvalid && m_tuser |-> m_tdata == '0, "oor payload")
	`ASSERT_CLK(a_empty_ready, clk, arst_n, !m_tvalid |-> s_tready, "stall with empty output")
	`ASSERT_NEVER(a_weight_max, clk, arst_n, m_tvalid && m_tdata[WEIGHT_W-1], "weight too large")

endmodule

>>> tb/cubic_bspline_shape_weight_2d_chk.sv
`timescale 1ns / 100ps
// Checker for the B-spline weight block: predicts each node result and compares it on the master side.
module cubic_bspline_shape_weight_2d_chk (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [cbsw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cbsw_pkg::DATA_W-1:0]      cfg_data,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [cbsw_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [cbsw_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                             m_tuser,
	output int                               errors,
	output int                               pending,
	output int                               nodes_checked,
	output int                               nodes_beyond
);
	import cbsw_pkg::*;

	localparam int F = FRAC_BITS_DEF;
	localparam logic [63:0] ONE_Q        = 64'd1 << F;
	localparam logic [63:0] TWO_Q        = 64'd2 << F;
	localparam logic [63:0] TWO_THIRDS_Q = ((64'd2 << F) + 64'd1) / 64'd3;
	localparam logic [63:0] WRAP_32      = 64'h1_0000_0000;

	typedef struct packed {
		logic [WEIGHT_W-1:0] weight;
		logic [DATA_W-1:0]   grad_x;
		logic [DATA_W-1:0]   grad_y;
		logic                beyond;
	} node_result_t;

	logic [DATA_W-1:0] inv_x;
	logic [DATA_W-1:0] inv_y;
	node_result_t      expected_nodes [$];
	int                mismatches = 0;
	int                checked = 0;
	int                beyond = 0;

	assign errors        = mismatches;
	assign nodes_checked = checked;
	assign nodes_beyond  = beyond;

	// Weight and slope magnitude of one axis for a scaled magnitude below two.
	function automatic void spline_axis(input logic [63:0] a, output logic [63:0] w,
			output logic [63:0] slope);
		logic [63:0] sq, cu, d;
		if (a < ONE_Q) begin
			sq = (a * a) >> F;
			cu = (sq * a) >> F;
			w = (cu >> 1) + TWO_THIRDS_Q - sq;
			slope = 2 * a - ((3 * sq) >> 1);
		end else begin
			d = TWO_Q - a;
			sq = (d * d) >> F;
			cu = (sq * d) >> F;
			w = cu / 6;
			slope = sq >> 1;
		end
	endfunction

	// Gradient points against the offset; saturate to the signed 32-bit range.
	function automatic logic [DATA_W-1:0] axis_grad(logic [63:0] slope, logic [DATA_W-1:0] inv,
			logic [63:0] w_other, logic neg);
		logic [63:0] mag;
		mag = (((slope * inv) >> F) * w_other) >> F;
		if (neg)
			return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
		if (mag > 64'h8000_0000)
			mag = 64'h8000_0000;
		return 32'(WRAP_32 - mag);
	endfunction

	function automatic node_result_t node_weight(logic [DATA_W-1:0] ox, oy, kx, ky);
		logic [63:0] mx, my, ax, ay, wx, wy, sx, sy;
		node_result_t r;
		mx = ox[DATA_W-1] ? WRAP_32 - ox : {32'd0, ox};
		my = oy[DATA_W-1] ? WRAP_32 - oy : {32'd0, oy};
		ax = (mx * kx) >> F;
		ay = (my * ky) >> F;
		r = '0;
		if (ax >= TWO_Q || ay >= TWO_Q) begin
			r.beyond = 1'b1;
			return r;
		end
		spline_axis(ax, wx, sx);
		spline_axis(ay, wy, sy);
		r.weight = 16'((wx * wy) >> (2 * F - 16));
		r.grad_x = axis_grad(sx, kx, wy, ox[DATA_W-1]);
		r.grad_y = axis_grad(sy, ky, wx, oy[DATA_W-1]);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
		mismatches++;
		$display("%0t ns: %s mismatch, got %h, expected %h", $realtime, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		node_result_t want;
		if (!arst_n) begin
			inv_x = 32'(ONE_Q);
			inv_y = 32'(ONE_Q);
			expected_nodes.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_INV_CELL_X: inv_x = cfg_data;
					CFG_INV_CELL_Y: inv_y = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_nodes.insert(expected_nodes.size(),
					node_weight(s_tdata[31:0], s_tdata[63:32], inv_x, inv_y));
			if (m_tvalid && m_tready) begin
				if (expected_nodes.size() == 0) begin
					report_mismatch("unrequested result", m_tdata[31:0], '0);
				end else begin
					want = expected_nodes.pop_front();
					checked++;
					if (want.beyond)
						beyond++;
					if (m_tdata[15:0] !== want.weight)
						report_mismatch("weight", 32'(m_tdata[15:0]), 32'(want.weight));
					if (m_tdata[47:16] !== want.grad_x)
						report_mismatch("grad_x", m_tdata[47:16], want.grad_x);
					if (m_tdata[79:48] !== want.grad_y)
						report_mismatch("grad_y", m_tdata[79:48], want.grad_y);
					if (m_tuser !== want.beyond)
						report_mismatch("out_of_range", 32'(m_tuser), 32'(want.beyond));
				end
			end
			pending <= expected_nodes.size();
		end
	end
endmodule

>>> tb/cubic_bspline_shape_weight_2d_tb.sv
`timescale 1ns / 100ps
// Testbench top for the B-spline weight block: drives offsets and register writes, gives the verdict.
module cubic_bspline_shape_weight_2d_tb;
	import cbsw_pkg::*;

	localparam int N_PHASES    = 8;
	localparam int PHASE_ITEMS = 86;
	localparam int STUCK_LIMIT = 1000;
	localparam int END_PAUSE   = 20;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [DATA_W-1:0]      cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;   // offset_x, offset_y
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;        // weight, grad_x, grad_y
	logic                   m_tuser;        // out_of_range

	int errors;
	int pending;
	int nodes_checked;
	int nodes_beyond;
	int stuck = 0;
	bit idle_on = 1'b1;

	// Inverse cell lengths per phase; the two random pairs are filled in at start.
	logic [DATA_W-1:0] phase_kx [N_PHASES] = '{32'h0001_0000, 32'h0000_0001, 32'hFFFF_FFFF,
		32'h0000_0000, 32'h0000_4000, 32'hAAAA_AAAA, 32'h0, 32'h0};
	logic [DATA_W-1:0] phase_ky [N_PHASES] = '{32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0001,
		32'h0002_8000, 32'h0000_0000, 32'h0002_0000, 32'h0, 32'h0};

	// Corner offsets at reset scaling, packed as {offset_y, offset_x}.
	logic [IN_TDATA_W-1:0] corner_offsets [] = '{
		{32'h0000_0000, 32'h0000_0000},
		{32'h0000_0000, 32'h0000_FFFF},
		{32'h0000_0000, 32'h0001_0000},
		{32'h0000_8000, 32'hFFFF_0000},
		{32'hFFFE_0001, 32'h0001_FFFF},
		{32'h0000_0000, 32'h0002_0000},
		{32'hFFFE_0000, 32'h0000_0000},
		{32'h8000_0000, 32'h7FFF_FFFF},
		{32'h0000_0000, 32'h8000_0000},
		{32'h7FFF_FFFF, 32'h0000_0000},
		{32'hFFFF_FFFF, 32'h0000_0001},
		{32'hFFFF_5555, 32'h0000_AAAB},
		{32'hFFFE_8000, 32'h0001_8000},
		{32'h0001_FFFF, 32'hFFFE_0001},
		{32'hFFFF_0000, 32'h0001_0000}
	};

	cubic_bspline_shape_weight_2d dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	cubic_bspline_shape_weight_2d_chk chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.errors       (errors),
		.pending      (pending),
		.nodes_checked(nodes_checked),
		.nodes_beyond (nodes_beyond)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stuck <= 0;
		else
			stuck <= stuck + 1;
		if (stuck >= STUCK_LIMIT) begin
			$display("FAIL cubic_bspline_shape_weight_2d");
			$finish;
		end
	end

	// Stall the result side in bursts of random length while idle_on is set.
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(0, 9);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Leaves cfg_valid high; the caller drops it after the last write.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic send_offsets(logic [IN_TDATA_W-1:0] word);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Mostly offsets whose scaled magnitude lands inside or just past the support.
	function automatic logic [DATA_W-1:0] pick_offset(logic [DATA_W-1:0] inv);
		logic [63:0] target, mag;
		if (inv == 0 || $urandom_range(0, 9) == 0)
			return $urandom;
		target = $urandom_range(0, 32'h0002_3333);
		mag = (target << FRAC_BITS_DEF) / inv;
		if ($urandom_range(0, 1))
			mag = mag + 1;
		if (mag > 64'h7FFF_FFFF)
			mag = 64'h7FFF_FFFF;
		return $urandom_range(0, 1) ? 32'(-mag[31:0]) : mag[31:0];
	endfunction

	initial begin
		phase_kx[6] = $urandom;
		phase_ky[6] = $urandom;
		phase_kx[7] = $urandom_range(32'h0000_2000, 32'h0004_0000);
		phase_ky[7] = $urandom_range(32'h0000_2000, 32'h0004_0000);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_offsets[i])
			send_offsets(corner_offsets[i]);
		drain_results();

		for (int p = 0; p < N_PHASES; p++) begin
			write_reg(CFG_INV_CELL_X, phase_kx[p]);
			write_reg(CFG_INV_CELL_Y, phase_ky[p]);
			if (p == 3) begin
				write_reg(CFG_SPARE_LO, $urandom);
				write_reg(CFG_SPARE_HI, $urandom);
			end
			cfg_valid <= 1'b0;
			// Run a calm phase, without stalls or gaps, as the third and as the last phase.
			idle_on = (p != 2 && p != N_PHASES - 1);
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_offsets({pick_offset(phase_ky[p]), pick_offset(phase_kx[p])});
			drain_results();
		end

		repeat (END_PAUSE) @(posedge clk);
		$display("Checked %0d node offsets over %0d inverse cell settings,", nodes_checked,
			N_PHASES + 1);
		$display("%0d of them beyond the spline support.", nodes_beyond);
		if (errors == 0 && pending == 0)
			$display("PASS cubic_bspline_shape_weight_2d");
		else
			$display("FAIL cubic_bspline_shape_weight_2d");
		$finish;
	end
endmodule

>>> files.f
+incdir+hdl
hdl/cbsw_pkg.sv
hdl/cubic_bspline_shape_weight_2d.sv
tb/cubic_bspline_shape_weight_2d_chk.sv
tb/cubic_bspline_shape_weight_2d_tb.sv
